FILE: sv/lirht_pkg.sv
// ----------------------------------------------------------------------------
// lirht_pkg: shared types and constants for the resampler and hop tagger
// Holds the field widths, the gain constants, the register indexes and the
// structs that travel between the front end, the queue, the back end and the top level.
// ----------------------------------------------------------------------------
package lirht_pkg;

    // Field widths of the input and result words.
    localparam int SAMPLE_W   = 16;
    localparam int SCALED_W   = 17;
    localparam int TAG_W      = 32;
    localparam int GAIN_W     = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP   = 8'd0,
        CFG_GAIN_PERCENT = 8'd1
    } cfg_index_t;

    // Gain handling: clamp, reset value and the reciprocal of 100.
    // floor(x / 100) == (x * RECIP_MULT) >> RECIP_SHIFT for every x below 2^23.
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 8'd200;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd100;
    localparam int                PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int                MAG_W      = 23;
    localparam int                RECIP_W    = 24;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 24'd10737419;
    localparam int                RECIP_SHIFT = 30;

    // Outputs caused by one input word.
    localparam int MAX_OUT   = 6;
    localparam int OUT_CNT_W = 3;

    // Scaled sample and its epoch tag, as queued between front and back.
    typedef struct packed {
        logic signed [SCALED_W-1:0] sample;
        logic [TAG_W-1:0]           tag;
    } scaled_word_t;

    // Back end status, watched by the top level.
    typedef struct packed {
        logic                 running;
        logic [1:0]           pair_fill;
        logic [OUT_CNT_W-1:0] out_count;
    } back_status_t;

endpackage

FILE: sv/lirht_front.sv
// ----------------------------------------------------------------------------
// lirht_front: input acceptance and gain scaling
// Two stages: the sample times the clamped gain, then a divide by 100 done as
// a multiply by a reciprocal on the magnitude, truncating toward zero.
// ----------------------------------------------------------------------------
module lirht_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [lirht_pkg::GAIN_W-1:0]         gain_percent,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [lirht_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [lirht_pkg::TAG_W-1:0]          s_epoch,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output lirht_pkg::scaled_word_t              push_word
);

    logic [lirht_pkg::GAIN_W-1:0]                 gain_clamped;
    logic signed [lirht_pkg::PROD_W-1:0]          gain_prod;
    logic                                         st1_valid_reg;
    logic signed [lirht_pkg::PROD_W-1:0]          st1_prod_reg;
    logic [lirht_pkg::TAG_W-1:0]                  st1_tag_reg;
    logic                                         st1_adv;
    logic [lirht_pkg::PROD_W-1:0]                 st1_abs;
    logic [lirht_pkg::MAG_W+lirht_pkg::RECIP_W-1:0] recip_prod;
    logic                                         st2_valid_reg;
    logic [lirht_pkg::SCALED_W-1:0]               st2_mag_reg;
    logic                                         st2_neg_reg;
    logic [lirht_pkg::TAG_W-1:0]                  st2_tag_reg;
    logic                                         st2_free;

    // Gain values above the maximum act as the maximum.
    assign gain_clamped = (gain_percent > lirht_pkg::GAIN_MAX) ? lirht_pkg::GAIN_MAX
                                                               : gain_percent;
    assign gain_prod = s_sample * $signed({1'b0, gain_clamped});

    // Stage handshakes.
    assign st2_free = !st2_valid_reg || push_ready;
    assign st1_adv  = st1_valid_reg && st2_free;
    assign s_ready  = !st1_valid_reg || st2_free;

    // Magnitude of the gain product, divided by 100 through the reciprocal.
    assign st1_abs    = st1_prod_reg[lirht_pkg::PROD_W-1] ? (-st1_prod_reg) : st1_prod_reg;
    assign recip_prod = st1_abs[lirht_pkg::MAG_W-1:0] * lirht_pkg::RECIP_MULT;

    // Stage 1: gain product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            st1_prod_reg <= gain_prod;
            st1_tag_reg  <= s_epoch;
        end
    end

    // Stage 2: quotient magnitude and sign.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (st2_free) begin
            st2_valid_reg <= st1_valid_reg;
        end
        if (st1_adv) begin
            st2_mag_reg <= recip_prod[lirht_pkg::RECIP_SHIFT +: lirht_pkg::SCALED_W];
            st2_neg_reg <= st1_prod_reg[lirht_pkg::PROD_W-1];
            st2_tag_reg <= st1_tag_reg;
        end
    end

    // Restore the sign and hand the word to the queue.
    assign push_valid       = st2_valid_reg;
    assign push_word.sample = st2_neg_reg ? $signed(-st2_mag_reg) : $signed(st2_mag_reg);
    assign push_word.tag    = st2_tag_reg;

endmodule

FILE: sv/lirht_queue.sv
// ----------------------------------------------------------------------------
// lirht_queue: short word queue between the front end and the back end
// Four entries, registered pointers and a fill count.
// ----------------------------------------------------------------------------
module lirht_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  lirht_pkg::scaled_word_t push_word,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output lirht_pkg::scaled_word_t pop_word
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    lirht_pkg::scaled_word_t entry_reg [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W:0]          count_reg;
    logic                    push_fire;
    logic                    pop_fire;

    assign push_ready = count_reg != (PTR_W+1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_word   = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/lirht_back.sv
// ----------------------------------------------------------------------------
// lirht_back: sample pair, phase sequencer, interpolation and hop tagging
// Takes one scaled word, updates the held pair and the phase, then emits up
// to six interpolated words through a multiply stage and an output register.
// ----------------------------------------------------------------------------
module lirht_back #(
    parameter int HOP_LENGTH = 480,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [FRAC_BITS+2:0]                  phase_step,
    input  logic                                  pop_valid,
    output logic                                  pop_ready,
    input  lirht_pkg::scaled_word_t               pop_word,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lirht_pkg::SCALED_W-1:0] m_resampled,
    output logic                                  m_hop_end,
    output logic [lirht_pkg::TAG_W-1:0]           m_hop_epoch,
    output logic                                  m_last,
    output lirht_pkg::back_status_t               status
);

    localparam int PHASE_W = FRAC_BITS + 3;
    localparam int HOP_W   = (HOP_LENGTH > 1) ? $clog2(HOP_LENGTH) : 1;
    localparam int DIFF_W  = lirht_pkg::SCALED_W + 1;
    localparam int MUL_W   = DIFF_W + FRAC_BITS + 1;
    localparam int SUM_W   = DIFF_W + 1;
    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
    localparam logic [HOP_W-1:0]   HOP_LAST  = HOP_W'(HOP_LENGTH - 1);
    localparam logic [lirht_pkg::OUT_CNT_W-1:0] OUT_LAST =
        lirht_pkg::OUT_CNT_W'(lirht_pkg::MAX_OUT - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } back_state_t;

    back_state_t                          state_reg, state_next;
    logic signed [lirht_pkg::SCALED_W-1:0] left_sample_reg, left_sample_next;
    logic signed [lirht_pkg::SCALED_W-1:0] right_sample_reg, right_sample_next;
    logic [lirht_pkg::TAG_W-1:0]          left_tag_reg, left_tag_next;
    logic [lirht_pkg::TAG_W-1:0]          right_tag_reg, right_tag_next;
    logic [1:0]                           pair_fill_reg, pair_fill_next;
    logic [PHASE_W-1:0]                   phase_reg, phase_next;
    logic [HOP_W-1:0]                     hop_count_reg, hop_count_next;
    logic [lirht_pkg::TAG_W-1:0]          hop_tag_reg, hop_tag_next;
    logic [lirht_pkg::OUT_CNT_W-1:0]      out_cnt_reg, out_cnt_next;

    logic                                 b_valid_reg;
    logic signed [MUL_W-1:0]              b_prod_reg;
    logic signed [lirht_pkg::SCALED_W-1:0] b_left_reg;
    logic                                 b_end_reg;
    logic [lirht_pkg::TAG_W-1:0]          b_tag_reg;
    logic                                 b_last_reg;

    logic                                 out_free;
    logic                                 b_adv;
    logic                                 b_free;
    logic                                 a_fire;
    logic                                 pop_fire;
    logic signed [DIFF_W-1:0]             a_diff;
    logic signed [FRAC_BITS:0]            a_frac;
    logic signed [MUL_W-1:0]              a_prod;
    logic [PHASE_W:0]                     phase_sum;
    logic [PHASE_W-1:0]                   phase_adv;
    logic [PHASE_W-1:0]                   phase_sub;
    logic                                 a_cont;
    logic                                 a_hop_end;
    logic [lirht_pkg::TAG_W-1:0]          a_tag;
    logic signed [MUL_W-1:0]              b_shifted;
    logic signed [SUM_W-1:0]              b_sum;

    // Handshakes through the multiply stage and the output register.
    assign out_free  = !m_valid || m_ready;
    assign b_adv     = b_valid_reg && out_free;
    assign b_free    = !b_valid_reg || b_adv;
    assign a_fire    = (state_reg == ST_RUN) && b_free;
    assign pop_ready = state_reg == ST_IDLE;
    assign pop_fire  = pop_valid && pop_ready;

    // Interpolation product for the current phase, which is below one here.
    assign a_diff = {right_sample_reg[lirht_pkg::SCALED_W-1], right_sample_reg}
                  - {left_sample_reg[lirht_pkg::SCALED_W-1], left_sample_reg};
    assign a_frac = {1'b0, phase_reg[FRAC_BITS-1:0]};
    assign a_prod = a_diff * a_frac;

    // Phase advance saturates; the phase drop on a new word floors at zero.
    assign phase_sum = {1'b0, phase_reg} + {1'b0, phase_step};
    assign phase_adv = phase_sum[PHASE_W] ? PHASE_MAX : phase_sum[PHASE_W-1:0];
    assign phase_sub = (phase_reg >= PHASE_ONE) ? (phase_reg - PHASE_ONE) : '0;
    assign a_cont    = (phase_adv < PHASE_ONE) && (out_cnt_reg != OUT_LAST);

    // Hop tag: the first word of a hop takes the shared tag, later words keep
    // it only while both held tags still match it.
    always_comb begin
        if (hop_count_reg == '0) begin
            a_tag = (left_tag_reg != '0 && left_tag_reg == right_tag_reg) ? left_tag_reg
                                                                          : '0;
        end else if (hop_tag_reg != left_tag_reg || hop_tag_reg != right_tag_reg) begin
            a_tag = '0;
        end else begin
            a_tag = hop_tag_reg;
        end
    end
    assign a_hop_end = hop_count_reg == HOP_LAST;

    // Sequencer: take a word in idle, then issue one output per cycle unless stalled.
    always_comb begin
        state_next        = state_reg;
        left_sample_next  = left_sample_reg;
        right_sample_next = right_sample_reg;
        left_tag_next     = left_tag_reg;
        right_tag_next    = right_tag_reg;
        pair_fill_next    = pair_fill_reg;
        phase_next        = phase_reg;
        hop_count_next    = hop_count_reg;
        hop_tag_next      = hop_tag_reg;
        out_cnt_next      = out_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_fire) begin
                    out_cnt_next = '0;
                    case (pair_fill_reg)
                        2'd0: begin
                            left_sample_next = pop_word.sample;
                            left_tag_next    = pop_word.tag;
                            pair_fill_next   = 2'd1;
                        end
                        2'd1: begin
                            right_sample_next = pop_word.sample;
                            right_tag_next    = pop_word.tag;
                            pair_fill_next    = 2'd2;
                            state_next        = ST_RUN;
                        end
                        default: begin
                            left_sample_next  = right_sample_reg;
                            left_tag_next     = right_tag_reg;
                            right_sample_next = pop_word.sample;
                            right_tag_next    = pop_word.tag;
                            pair_fill_next    = 2'd2;
                            phase_next        = phase_sub;
                            if (phase_sub < PHASE_ONE) begin
                                state_next = ST_RUN;
                            end
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (a_fire) begin
                    phase_next     = phase_adv;
                    hop_tag_next   = a_tag;
                    hop_count_next = a_hop_end ? '0 : hop_count_reg + 1'b1;
                    out_cnt_next   = out_cnt_reg + 1'b1;
                    if (!a_cont) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer and pair registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pair_fill_reg <= '0;
            phase_reg     <= '0;
            hop_count_reg <= '0;
            hop_tag_reg   <= '0;
            out_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            pair_fill_reg <= pair_fill_next;
            phase_reg     <= phase_next;
            hop_count_reg <= hop_count_next;
            hop_tag_reg   <= hop_tag_next;
            out_cnt_reg   <= out_cnt_next;
        end
        left_sample_reg  <= left_sample_next;
        right_sample_reg <= right_sample_next;
        left_tag_reg     <= left_tag_next;
        right_tag_reg    <= right_tag_next;
    end

    // Multiply stage: product, left sample and word flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_fire;
        end
        if (a_fire) begin
            b_prod_reg <= a_prod;
            b_left_reg <= left_sample_reg;
            b_end_reg  <= a_hop_end;
            b_tag_reg  <= a_tag;
            b_last_reg <= !a_cont;
        end
    end

    // Floor shift of the product, added to the left sample.
    assign b_shifted = b_prod_reg >>> FRAC_BITS;
    assign b_sum     = b_shifted[SUM_W-1:0]
                     + {{(SUM_W-lirht_pkg::SCALED_W){b_left_reg[lirht_pkg::SCALED_W-1]}},
                        b_left_reg};

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= b_valid_reg;
        end
        if (b_adv) begin
            m_resampled <= b_sum[lirht_pkg::SCALED_W-1:0];
            m_hop_end   <= b_end_reg;
            m_hop_epoch <= b_tag_reg;
            m_last      <= b_last_reg;
        end
    end

    assign status.running   = state_reg == ST_RUN;
    assign status.pair_fill = pair_fill_reg;
    assign status.out_count = out_cnt_reg;

endmodule

FILE: sv/linear_interp_resampler_hop_tagger.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_hop_tagger: gain, linear resampler and hop tagging
// Scales tagged capture samples by a percent gain, converts them to the
// output rate by linear interpolation and tags hops with a shared epoch.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one capture word (sample, epoch) per handshake. m_* returns
//   interpolated words with hop_end, hop_epoch and last; last marks the final
//   word caused by one input word. cfg_* writes phase_step (index 0) and
//   gain_percent (index 1); write them only while the block is idle.
// Path: from input acceptance to the first output word on an idle block, a
//   word passes the second gain stage, the queue write, the sequencer, the
//   multiply stage and the output register.
// Sequencing: the sequencer takes a word only while idle and then issues each
//   output word it causes before it takes the next; the first word of a
//   stream causes no output.
// The front end keeps accepting into its two stages and a 4-word queue while
//   the back end works or the receiver stalls; a stalled output word holds.
// Reset clears the pair, the phase, the hop counter, the queue and all valid
//   flags, and sets phase_step to one and gain_percent to 100.
// ----------------------------------------------------------------------------
module linear_interp_resampler_hop_tagger #(
    parameter int HOP_LENGTH = 480,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [lirht_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lirht_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [lirht_pkg::SAMPLE_W-1:0]    s_sample,
    input  logic [lirht_pkg::TAG_W-1:0]              s_epoch,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [lirht_pkg::SCALED_W-1:0]    m_resampled,
    output logic                                     m_hop_end,
    output logic [lirht_pkg::TAG_W-1:0]              m_hop_epoch,
    output logic                                     m_last
);

    localparam int PHASE_W = FRAC_BITS + 3;
    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;

    logic [PHASE_W-1:0]               phase_step_reg;
    logic [lirht_pkg::GAIN_W-1:0]     gain_percent_reg;
    logic                             q_push_valid;
    logic                             q_push_ready;
    lirht_pkg::scaled_word_t          q_push_word;
    logic                             q_pop_valid;
    logic                             q_pop_ready;
    lirht_pkg::scaled_word_t          q_pop_word;
    lirht_pkg::back_status_t          back_status;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= PHASE_ONE;
            gain_percent_reg <= lirht_pkg::GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lirht_pkg::CFG_PHASE_STEP: begin
                    phase_step_reg <= cfg_data[PHASE_W-1:0];
                end
                lirht_pkg::CFG_GAIN_PERCENT: begin
                    gain_percent_reg <= cfg_data[lirht_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: accept and scale.
    lirht_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .gain_percent (gain_percent_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_epoch      (s_epoch),
        .push_valid   (q_push_valid),
        .push_ready   (q_push_ready),
        .push_word    (q_push_word)
    );

    // Queue between the two halves.
    lirht_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_word  (q_push_word),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_word   (q_pop_word)
    );

    // Back end: interpolate and tag.
    lirht_back #(
        .HOP_LENGTH (HOP_LENGTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .phase_step  (phase_step_reg),
        .pop_valid   (q_pop_valid),
        .pop_ready   (q_pop_ready),
        .pop_word    (q_pop_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_resampled (m_resampled),
        .m_hop_end   (m_hop_end),
        .m_hop_epoch (m_hop_epoch),
        .m_last      (m_last),
        .status      (back_status)
    );

    // The output count of a run never reaches the per-word cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.running |-> back_status.out_count < lirht_pkg::OUT_CNT_W'(lirht_pkg::MAX_OUT))
        else $error("output count reached the per-word cap during a run");

    // The queue is only drained while the sequencer is not running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop_valid && q_pop_ready) |-> !back_status.running)
        else $error("queue popped during a run");

    // The word that completes the pair always starts a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop_valid && q_pop_ready && back_status.pair_fill == 2'd1)
        |=> back_status.running)
        else $error("second word did not start a run");

endmodule

FILE: tb/sv/linear_interp_resampler_hop_tagger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_hop_tagger_tb: self-checking bench for the resampler
// Streams tagged capture words into the block under bursty input and a
// stalling output. It predicts every interpolated word, including hop ends,
// hop epochs and last flags, with its own model of the gain, the phase
// accumulator and the hop tagger, and compares each output word field by
// field. A directed table covers the field extremes, the gain clamp, the
// output cap and phase saturation. Randomized register settings follow.
// ----------------------------------------------------------------------------
module linear_interp_resampler_hop_tagger_tb;

    localparam int      HOP_LEN        = 480;
    localparam int      FRAC           = 16;
    localparam longint  PHASE_ONE      = 64'd1 << FRAC;
    localparam longint  PHASE_MAX      = (64'd1 << (FRAC + 3)) - 1;
    localparam int      PERCENT        = 100;
    localparam int      STEP_MIN       = 10923;
    localparam int      STEP_MAX       = 262144;
    localparam int      STEP_UNITY     = 65536;
    localparam logic [31:0] STEP_MASK  = 32'h0007_FFFF;
    localparam logic [31:0] GAIN_MASK  = 32'h0000_00FF;
    localparam int      SETTLE_CYCLES  = 32;
    localparam int      WATCHDOG_LIMIT = 2000;
    localparam int      RANDOM_PHASES  = 3;

    // One output word as the block should present it.
    typedef struct packed {
        logic signed [lirht_pkg::SCALED_W-1:0] resampled;
        logic                                  hop_end;
        logic [lirht_pkg::TAG_W-1:0]           hop_epoch;
        logic                                  last;
    } out_word_t;

    // One row of the directed table: a register write or an input word.
    typedef struct packed {
        logic                                  is_write;
        lirht_pkg::cfg_index_t                 reg_idx;
        logic [lirht_pkg::CFG_DATA_W-1:0]      reg_val;
        logic signed [lirht_pkg::SAMPLE_W-1:0] sample;
        logic [lirht_pkg::TAG_W-1:0]           epoch;
        logic                                  has_typed;
        logic signed [lirht_pkg::SCALED_W-1:0] typed_val;
    } stim_row_t;

    logic                                  aclk      = 1'b0;
    logic                                  aresetn   = 1'b0;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [lirht_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [lirht_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                                  s_valid   = 1'b0;
    logic                                  s_ready;
    logic signed [lirht_pkg::SAMPLE_W-1:0] s_sample  = '0;
    logic [lirht_pkg::TAG_W-1:0]           s_epoch   = '0;
    logic                                  m_valid;
    logic                                  m_ready   = 1'b0;
    logic signed [lirht_pkg::SCALED_W-1:0] m_resampled;
    logic                                  m_hop_end;
    logic [lirht_pkg::TAG_W-1:0]           m_hop_epoch;
    logic                                  m_last;

    // Predictor state and its copy of the registers.
    logic [18:0]                           step_reg;
    logic [lirht_pkg::GAIN_W-1:0]          gain_pct;
    logic signed [lirht_pkg::SCALED_W-1:0] left_s;
    logic signed [lirht_pkg::SCALED_W-1:0] right_s;
    logic [lirht_pkg::TAG_W-1:0]           left_t;
    logic [lirht_pkg::TAG_W-1:0]           right_t;
    int                                    pair_fill;
    longint                                phase_acc;
    int                                    hop_fill;
    logic [lirht_pkg::TAG_W-1:0]           run_tag;

    out_word_t                    pending_outputs[$];
    stim_row_t                    stim_rows[$];
    int                           fail_count  = 0;
    int                           burst_left  = 0;
    int                           idle_cycles = 0;
    logic [7:0]                   rx_cycle    = '0;

    linear_interp_resampler_hop_tagger #(
        .HOP_LENGTH (HOP_LEN),
        .FRAC_BITS  (FRAC)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_epoch     (s_epoch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_resampled (m_resampled),
        .m_hop_end   (m_hop_end),
        .m_hop_epoch (m_hop_epoch),
        .m_last      (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Scale one input word and queue the interpolated words it causes.
    task automatic predict_resampled(input logic signed [lirht_pkg::SAMPLE_W-1:0] smp,
                                     input logic [lirht_pkg::TAG_W-1:0] ep);
        int        g;
        int        scaled;
        int        emitted;
        longint    prod;
        longint    value;
        out_word_t w;
        g = (gain_pct > lirht_pkg::GAIN_MAX) ? int'(lirht_pkg::GAIN_MAX) : int'(gain_pct);
        scaled = (int'(smp) * g) / PERCENT;
        emitted = 0;
        if (pair_fill == 0) begin
            left_s = lirht_pkg::SCALED_W'(scaled);
            left_t = ep;
            pair_fill = 1;
            return;
        end
        if (pair_fill == 1) begin
            right_s = lirht_pkg::SCALED_W'(scaled);
            right_t = ep;
            pair_fill = 2;
        end else begin
            left_s = right_s;
            left_t = right_t;
            right_s = lirht_pkg::SCALED_W'(scaled);
            right_t = ep;
            phase_acc = (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : 0;
        end
        while (phase_acc < PHASE_ONE && emitted < lirht_pkg::MAX_OUT) begin
            // Floor of the weighted difference: arithmetic shift rounds down.
            prod = (longint'(right_s) - longint'(left_s)) * phase_acc;
            value = longint'(left_s) + (prod >>> FRAC);
            w.resampled = value[lirht_pkg::SCALED_W-1:0];
            if (hop_fill == 0) begin
                run_tag = (left_t != '0 && left_t == right_t) ? left_t : '0;
            end else if (run_tag != left_t || run_tag != right_t) begin
                run_tag = '0;
            end
            hop_fill++;
            w.hop_end = 1'b0;
            if (hop_fill >= HOP_LEN) begin
                w.hop_end = 1'b1;
                hop_fill = 0;
            end
            w.hop_epoch = run_tag;
            w.last = 1'b0;
            pending_outputs.push_back(w);
            emitted++;
            phase_acc += step_reg;
            if (phase_acc > PHASE_MAX) begin
                phase_acc = PHASE_MAX;
            end
        end
        if (emitted > 0) begin
            w = pending_outputs.pop_back();
            w.last = 1'b1;
            pending_outputs.push_back(w);
        end
    endtask

    // Present one word and hold it until accepted, then maybe open a gap.
    // A typed value replaces the predicted sample of the word's only output.
    task automatic send_word(input logic signed [lirht_pkg::SAMPLE_W-1:0] smp,
                             input logic [lirht_pkg::TAG_W-1:0] ep,
                             input logic has_typed = 1'b0,
                             input logic signed [lirht_pkg::SCALED_W-1:0] typed_val = '0);
        int        gap;
        out_word_t w;
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_epoch  <= ep;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_resampled(smp, ep);
        if (has_typed) begin
            w = pending_outputs.pop_back();
            w.resampled = typed_val;
            pending_outputs.push_back(w);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 7))
                0: gap = 0;
                7: gap = $urandom_range(20, 40);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stop sending, let every expected word arrive and the pipeline empty.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register on an idle block and mirror it in the predictor.
    task automatic write_reg(input lirht_pkg::cfg_index_t idx,
                             input logic [lirht_pkg::CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == lirht_pkg::CFG_PHASE_STEP) begin
            step_reg = val[18:0];
        end else if (idx == lirht_pkg::CFG_GAIN_PERCENT) begin
            gain_pct = val[lirht_pkg::GAIN_W-1:0];
        end
        @(posedge aclk);
    endtask

    function automatic void add_item(input int smp, input logic [lirht_pkg::TAG_W-1:0] ep,
                                     input logic has_typed, input int typed_val);
        stim_row_t r;
        r = '0;
        r.sample = lirht_pkg::SAMPLE_W'(smp);
        r.epoch = ep;
        r.has_typed = has_typed;
        r.typed_val = lirht_pkg::SCALED_W'(typed_val);
        stim_rows.push_back(r);
    endfunction

    function automatic void add_write(input lirht_pkg::cfg_index_t idx,
                                      input logic [lirht_pkg::CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        stim_rows.push_back(r);
    endfunction

    // Receiver: cycles through free flow, random stalls, sparse and long stalls.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[7:6])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= (rx_cycle[1:0] == 2'd0);
            default: m_ready <= (rx_cycle[4:0] > 5'd20);
        endcase
    end

    // Compare each output word with the oldest expected word.
    always @(posedge aclk) begin : check_words
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected word: resampled %0d hop_end %0d hop_epoch %0h last %0d",
                       m_resampled, m_hop_end, m_hop_epoch, m_last);
                fail_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_resampled !== want.resampled) begin
                    $error("resampled: expected %0d, actual %0d", want.resampled, m_resampled);
                    fail_count++;
                end
                if (m_hop_end !== want.hop_end) begin
                    $error("hop_end: expected %0d, actual %0d", want.hop_end, m_hop_end);
                    fail_count++;
                end
                if (m_hop_epoch !== want.hop_epoch) begin
                    $error("hop_epoch: expected %0h, actual %0h", want.hop_epoch, m_hop_epoch);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no channel has moved a word for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        stim_row_t                             row;
        logic [lirht_pkg::TAG_W-1:0]           run_epoch;
        logic [lirht_pkg::TAG_W-1:0]           ep;
        logic signed [lirht_pkg::SAMPLE_W-1:0] smp;
        int                                    step_val;
        int                                    gain_val;
        int                                    n_items;
        int                                    run_left;

        step_reg  = 19'(STEP_UNITY);
        gain_pct  = lirht_pkg::GAIN_RESET;
        left_s    = '0;
        right_s   = '0;
        left_t    = '0;
        right_t   = '0;
        pair_fill = 0;
        phase_acc = 0;
        hop_fill  = 0;
        run_tag   = '0;
        run_left  = 0;
        run_epoch = '0;

        // Unity step and gain: each word returns the previous sample as is.
        add_item(32767, 32'h0, 1'b0, 0);
        add_item(-32768, 32'h0, 1'b1, 32767);
        add_item(0, 32'hFFFF_FFFF, 1'b1, -32768);
        add_item(-1, 32'hFFFF_FFFF, 1'b1, 0);
        add_item(1, 32'hFFFF_FFFF, 1'b1, -1);
        // Full gain reaches the ends of the scaled range.
        add_write(lirht_pkg::CFG_GAIN_PERCENT, 32'd200);
        add_item(32767, 32'd5, 1'b1, 1);
        add_item(-32768, 32'd5, 1'b1, 65534);
        add_item(100, 32'd5, 1'b1, -65536);
        // Gains above the clamp act as full gain.
        add_write(lirht_pkg::CFG_GAIN_PERCENT, 32'd255);
        add_item(-32768, 32'd6, 1'b1, 200);
        add_item(12345, 32'd6, 1'b1, -65536);
        // Zero gain silences the input.
        add_write(lirht_pkg::CFG_GAIN_PERCENT, 32'd0);
        add_item(32767, 32'd7, 1'b1, 24690);
        add_item(-1, 32'd7, 1'b1, 0);
        // A zero step hits the output cap with the phase held.
        add_write(lirht_pkg::CFG_GAIN_PERCENT, 32'd100);
        add_write(lirht_pkg::CFG_PHASE_STEP, 32'd0);
        add_item(1000, 32'd8, 1'b0, 0);
        add_item(-1000, 32'd8, 1'b0, 0);
        // Slowest and fastest legal steps.
        add_write(lirht_pkg::CFG_PHASE_STEP, STEP_MIN);
        add_item(2000, 32'd9, 1'b0, 0);
        add_write(lirht_pkg::CFG_PHASE_STEP, STEP_MAX);
        add_item(-2000, 32'd9, 1'b0, 0);
        add_item(3000, 32'd9, 1'b0, 0);
        add_item(-3000, 32'd0, 1'b0, 0);
        add_item(21845, 32'd0, 1'b0, 0);
        add_item(-21846, 32'hFFFF_FFFF, 1'b0, 0);
        // Largest step: the phase saturates and words pass with no output.
        add_write(lirht_pkg::CFG_PHASE_STEP, 32'h0007_FFFF);
        add_item(7, 32'd1, 1'b0, 0);
        add_item(-7, 32'd1, 1'b0, 0);
        add_item(30000, 32'd2, 1'b0, 0);
        add_item(-30000, 32'd2, 1'b0, 0);
        add_item(123, 32'd3, 1'b0, 0);
        add_item(-123, 32'd3, 1'b0, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.is_write) begin
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_word(row.sample, row.epoch, row.has_typed, row.typed_val);
            end
        end

        // One long tagged run at six words per input, spanning a whole hop.
        write_reg(lirht_pkg::CFG_PHASE_STEP,
                  ($urandom & ~STEP_MASK) | $urandom_range(0, STEP_MIN - 1));
        write_reg(lirht_pkg::CFG_GAIN_PERCENT, ($urandom & ~GAIN_MASK) | $urandom_range(0, 255));
        run_epoch = $urandom | 32'h1;
        n_items = (HOP_LEN - hop_fill + lirht_pkg::MAX_OUT - 1) / lirht_pkg::MAX_OUT
                + HOP_LEN / lirht_pkg::MAX_OUT + 2;
        for (int k = 0; k < n_items; k++) begin
            smp = lirht_pkg::SAMPLE_W'($urandom);
            send_word(smp, run_epoch);
        end

        // Random register settings with runs of shared epochs and some noise.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0: step_val = STEP_MIN;
                1: step_val = STEP_MAX;
                2: step_val = $urandom_range(0, STEP_MIN - 1);
                3: step_val = STEP_MASK;
                4: step_val = STEP_UNITY;
                default: step_val = $urandom_range(STEP_MIN, STEP_MAX);
            endcase
            case ($urandom_range(0, 3))
                0: gain_val = 0;
                1: gain_val = lirht_pkg::GAIN_MAX;
                2: gain_val = lirht_pkg::GAIN_RESET;
                default: gain_val = $urandom_range(0, 255);
            endcase
            write_reg(lirht_pkg::CFG_PHASE_STEP, ($urandom & ~STEP_MASK) | step_val);
            write_reg(lirht_pkg::CFG_GAIN_PERCENT, ($urandom & ~GAIN_MASK) | gain_val);
            n_items = $urandom_range(1, 3);
            for (int k = 0; k < n_items; k++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 8);
                    case ($urandom_range(0, 3))
                        0: run_epoch = '0;
                        1: run_epoch = '1;
                        default: run_epoch = $urandom;
                    endcase
                end
                run_left--;
                ep = ($urandom_range(0, 5) == 0) ? $urandom : run_epoch;
                case ($urandom_range(0, 7))
                    0: smp = 16'sh7FFF;
                    1: smp = 16'sh8000;
                    default: smp = lirht_pkg::SAMPLE_W'($urandom);
                endcase
                send_word(smp, ep);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
